// ===== rtl/core/sack_pkg.sv =====
// sack_pkg: shared widths, codes and controller/datapath handshake types
// for the selective-ack scoreboard core. No dependencies.
package sack_pkg;

    localparam int SEQ_W     = 64;   // sequence numbers
    localparam int BITMAP_W  = 64;   // selective bitmap reach, both directions
    localparam int BIT_IDX_W = 6;    // bit index into a bitmap
    localparam int SEND_W    = 11;   // send_bytes field
    localparam int BYTES_W   = 17;   // in-flight byte counter
    localparam int CWND_W    = 32;   // congestion window
    localparam int FREED_W   = 7;    // released-slot count

    localparam logic [CWND_W-1:0] RESET_WINDOW = 32'd12000;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;         // latch the request, clear per-request results
        logic send_commit;  // claim the slot under the scan pointer
        logic send_next;    // step the scan pointer
        logic recv_mark;    // mark the peer sequence in the receive window
        logic recv_run;     // slot release scan and ack advance
        logic finish;       // load the response register
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_recv;
        logic send_ok;      // in-flight bytes below window
        logic slot_free;    // slot under the scan pointer is free
        logic scan_last;    // scan pointer on the last slot
        logic recv_done;    // scan issued, pipe drained, ack settled
        logic out_free;     // response register can take a new result
    } dp_status_t;

endpackage

// ===== rtl/core/sack_channels.sv =====
// Valid/ready channel interfaces of the selective-ack scoreboard core.
// Depends on sack_pkg for field widths.

interface sack_req_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic [sack_pkg::SEND_W-1:0]      send_bytes;
    logic [sack_pkg::SEQ_W-1:0]       peer_seq;
    logic [sack_pkg::SEQ_W-1:0]       peer_ack;
    logic [sack_pkg::BITMAP_W-1:0]    peer_bitmap;

    modport source (output valid, mode, send_bytes, peer_seq, peer_ack, peer_bitmap,
                    input ready);
    modport sink (input valid, mode, send_bytes, peer_seq, peer_ack, peer_bitmap,
                  output ready);
endinterface

interface sack_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             accepted;
    logic [sack_pkg::SEQ_W-1:0]       assigned_seq;
    logic [sack_pkg::SEQ_W-1:0]       local_ack;
    logic [sack_pkg::BITMAP_W-1:0]    local_bitmap;
    logic                             out_of_window;
    logic [sack_pkg::FREED_W-1:0]     freed_count;
    logic [sack_pkg::BYTES_W-1:0]     inflight_bytes;
    logic [sack_pkg::CWND_W-1:0]      window_bytes;

    modport source (output valid, accepted, assigned_seq, local_ack, local_bitmap,
                    out_of_window, freed_count, inflight_bytes, window_bytes,
                    input ready);
    modport sink (input valid, accepted, assigned_seq, local_ack, local_bitmap,
                  out_of_window, freed_count, inflight_bytes, window_bytes,
                  output ready);
endinterface

interface sack_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sack_pkg::CWND_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/selective_ack_scoreboard_core.sv =====
// selective_ack_scoreboard_core: top level of the selective-ack scoreboard.
// Depends on sack_pkg, sack_channels, sack_ctrl and sack_datapath.
//
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   mode, send_bytes, peer_seq, peer_ack, peer_bitmap
//  rsp_ch   out  valid/ready   accepted .. window_bytes, one per request
//  cfg_ch   in   valid/ready   data: congestion window, loaded at once
//
// One request at a time. A send scans the slots from the first to the first
// free one and claims it; it is refused on the byte window, or when no slot
// is free. A receive steps one slot per cycle through the slot memory read
// port and two pipe stages; the contiguous-ack slide over the filled head of
// the receive bitmap runs alongside.
// Reset clears the busy bits and counters at once; no clearing pass.
// The response register holds while rsp_ch stalls; a new request is taken
// meanwhile and waits for it only at its very end. cfg_ch is always ready.
module selective_ack_scoreboard_core #(
    parameter int WINDOW    = 64,
    parameter int SIZE_BITS = 11
) (
    input logic        clk,
    input logic        rst_n,
    sack_req_if.sink   req_ch,
    sack_rsp_if.source rsp_ch,
    sack_cfg_if.sink   cfg_ch
);

    sack_pkg::ctrl_cmd_t  cmd;
    sack_pkg::dp_status_t status;

    assign cfg_ch.ready = 1'b1;

    sack_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sack_datapath #(
        .WINDOW    (WINDOW),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .req_mode           (req_ch.mode),
        .req_send_bytes     (req_ch.send_bytes),
        .req_peer_seq       (req_ch.peer_seq),
        .req_peer_ack       (req_ch.peer_ack),
        .req_peer_bitmap    (req_ch.peer_bitmap),
        .cfg_write          (cfg_ch.valid),
        .cfg_data           (cfg_ch.data),
        .rsp_ready          (rsp_ch.ready),
        .rsp_valid          (rsp_ch.valid),
        .rsp_accepted       (rsp_ch.accepted),
        .rsp_assigned_seq   (rsp_ch.assigned_seq),
        .rsp_local_ack      (rsp_ch.local_ack),
        .rsp_local_bitmap   (rsp_ch.local_bitmap),
        .rsp_out_of_window  (rsp_ch.out_of_window),
        .rsp_freed_count    (rsp_ch.freed_count),
        .rsp_inflight_bytes (rsp_ch.inflight_bytes),
        .rsp_window_bytes   (rsp_ch.window_bytes)
    );

endmodule

// ===== rtl/core/sack_ctrl.sv =====
// sack_ctrl: request sequencer of the selective-ack scoreboard.
// Depends on sack_pkg (command/status types); drives sack_datapath.
module sack_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sack_pkg::dp_status_t status,
    output sack_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEND_SCAN,
        ST_RECV_RUN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign req_ready = ready_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.load = req_valid && ready_reg;
            ST_DISPATCH:  cmd.recv_mark = status.is_recv;
            ST_SEND_SCAN:
            begin
                cmd.send_commit = status.slot_free;
                cmd.send_next   = !status.slot_free && !status.scan_last;
            end
            ST_RECV_RUN:  cmd.recv_run = 1'b1;
            ST_FINISH:    cmd.finish = status.out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid && ready_reg)
                    begin
                        state_reg <= ST_DISPATCH;
                        ready_reg <= 1'b0;
                    end
                end
                ST_DISPATCH:
                begin
                    priority if (status.is_recv)
                        state_reg <= ST_RECV_RUN;
                    else if (status.send_ok)
                        state_reg <= ST_SEND_SCAN;
                    else
                        state_reg <= ST_FINISH;   // window full: refused
                end
                ST_SEND_SCAN:
                begin
                    if (status.slot_free || status.scan_last)
                        state_reg <= ST_FINISH;
                end
                ST_RECV_RUN:
                begin
                    if (status.recv_done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/sack_datapath.sv =====
// sack_datapath: slot store, byte/window accounting, receive window and
// response register. Depends on sack_pkg; sequenced by sack_ctrl.
module sack_datapath #(
    parameter int WINDOW    = 64,
    parameter int SIZE_BITS = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sack_pkg::ctrl_cmd_t              cmd,
    output sack_pkg::dp_status_t             status,
    input  logic                             req_mode,
    input  logic [sack_pkg::SEND_W-1:0]      req_send_bytes,
    input  logic [sack_pkg::SEQ_W-1:0]       req_peer_seq,
    input  logic [sack_pkg::SEQ_W-1:0]       req_peer_ack,
    input  logic [sack_pkg::BITMAP_W-1:0]    req_peer_bitmap,
    input  logic                             cfg_write,
    input  logic [sack_pkg::CWND_W-1:0]      cfg_data,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic                             rsp_accepted,
    output logic [sack_pkg::SEQ_W-1:0]       rsp_assigned_seq,
    output logic [sack_pkg::SEQ_W-1:0]       rsp_local_ack,
    output logic [sack_pkg::BITMAP_W-1:0]    rsp_local_bitmap,
    output logic                             rsp_out_of_window,
    output logic [sack_pkg::FREED_W-1:0]     rsp_freed_count,
    output logic [sack_pkg::BYTES_W-1:0]     rsp_inflight_bytes,
    output logic [sack_pkg::CWND_W-1:0]      rsp_window_bytes
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SEQ_W = sack_pkg::SEQ_W;
    localparam int BIX_W = sack_pkg::BIT_IDX_W;
    localparam int CW1_W = sack_pkg::CWND_W + 1;

    // latched request
    logic                            mode_reg;
    logic [sack_pkg::SEND_W-1:0]     send_bytes_reg;
    logic [SEQ_W-1:0]                pseq_reg;
    logic [SEQ_W-1:0]                pack_reg;
    logic [sack_pkg::BITMAP_W-1:0]   pbits_reg;

    // scoreboard state
    logic [SEQ_W-1:0]                next_seq_reg;
    logic [WINDOW-1:0]               busy_reg;
    logic [sack_pkg::BYTES_W-1:0]    bo_reg;
    logic [sack_pkg::CWND_W-1:0]     cwnd_reg;
    logic [SEQ_W-1:0]                contig_reg;
    logic [sack_pkg::BITMAP_W-1:0]   recv_bits_reg;

    logic [SEQ_W-1:0]                seq_mem [WINDOW];
    logic [SIZE_BITS-1:0]            size_mem [WINDOW];

    // per-request results
    logic                            accepted_reg;
    logic [SEQ_W-1:0]                assigned_reg;
    logic                            oow_reg;
    logic [sack_pkg::FREED_W-1:0]    freed_reg;

    // scan pointer and release pipe
    logic [CNT_W-1:0]                scan_cnt_reg;
    logic                            p1_valid_reg;
    logic                            p1_busy_reg;
    logic [IDX_W-1:0]                p1_idx_reg;
    logic [SEQ_W-1:0]                rd_seq_reg;
    logic [SIZE_BITS-1:0]            rd_size_reg;
    logic                            p2_valid_reg;
    logic [IDX_W-1:0]                p2_idx_reg;
    logic [SIZE_BITS-1:0]            p2_size_reg;

    // response register
    logic                            out_valid_reg;
    logic                            out_accepted_reg;
    logic [SEQ_W-1:0]                out_assigned_reg;
    logic [SEQ_W-1:0]                out_ack_reg;
    logic [sack_pkg::BITMAP_W-1:0]   out_bitmap_reg;
    logic                            out_oow_reg;
    logic [sack_pkg::FREED_W-1:0]    out_freed_reg;
    logic [sack_pkg::BYTES_W-1:0]    out_bytes_reg;
    logic [sack_pkg::CWND_W-1:0]     out_window_reg;

    logic [IDX_W-1:0]                idx;
    logic                            issue;
    logic                            out_free;
    logic [SIZE_BITS-1:0]            send_size;
    logic [sack_pkg::BYTES_W-1:0]    bo_add;
    logic [sack_pkg::BYTES_W-1:0]    bo_sub;
    logic [SEQ_W:0]                  rel_sum;
    logic                            release_hit;
    logic [SEQ_W:0]                  mark_sum;
    logic [CW1_W-1:0]                cwnd_sum;
    logic [sack_pkg::CWND_W-1:0]     cwnd_sat;

    assign idx      = scan_cnt_reg[IDX_W-1:0];
    assign issue    = cmd.recv_run && (scan_cnt_reg != CNT_W'(WINDOW));
    assign out_free = !out_valid_reg || rsp_ready;

    assign send_size = SIZE_BITS'(send_bytes_reg);
    assign bo_add    = bo_reg + sack_pkg::BYTES_W'(send_size);
    assign bo_sub    = bo_reg - sack_pkg::BYTES_W'(p2_size_reg);

    // seq + ~ack: carry out means seq > ack, low word is seq - ack - 1
    assign rel_sum     = {1'b0, rd_seq_reg} + {1'b0, ~pack_reg};
    assign release_hit = p1_valid_reg && p1_busy_reg &&
                         (!rel_sum[SEQ_W] ||
                          ((rel_sum[SEQ_W-1:BIX_W] == '0) && pbits_reg[rel_sum[BIX_W-1:0]]));

    assign mark_sum = {1'b0, pseq_reg} + {1'b0, ~contig_reg};

    assign cwnd_sum = {1'b0, cwnd_reg} + CW1_W'(p2_size_reg);
    assign cwnd_sat = cwnd_sum[CW1_W-1] ? '1 : cwnd_sum[CW1_W-2:0];

    always_comb
    begin
        status.is_recv   = (mode_reg == sack_pkg::MODE_RECV);
        status.send_ok   = (sack_pkg::CWND_W'(bo_reg) < cwnd_reg);
        status.slot_free = !busy_reg[idx];
        status.scan_last = (scan_cnt_reg == CNT_W'(WINDOW - 1));
        status.recv_done = (scan_cnt_reg == CNT_W'(WINDOW)) && !p1_valid_reg &&
                           !p2_valid_reg && !recv_bits_reg[0];
        status.out_free  = out_free;
    end

    // request latch, slot memory, pipe payload and response payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg       <= req_mode;
            send_bytes_reg <= req_send_bytes;
            pseq_reg       <= req_peer_seq;
            pack_reg       <= req_peer_ack;
            pbits_reg      <= req_peer_bitmap;
        end
        if (cmd.send_commit)
        begin
            seq_mem[idx]  <= next_seq_reg;
            size_mem[idx] <= send_size;
        end
        rd_seq_reg  <= seq_mem[idx];
        rd_size_reg <= size_mem[idx];
        p1_idx_reg  <= idx;
        p1_busy_reg <= busy_reg[idx];
        p2_idx_reg  <= p1_idx_reg;
        p2_size_reg <= rd_size_reg;
        if (cmd.finish)
        begin
            out_accepted_reg <= accepted_reg;
            out_assigned_reg <= assigned_reg;
            out_ack_reg      <= contig_reg;
            out_bitmap_reg   <= recv_bits_reg;
            out_oow_reg      <= oow_reg;
            out_freed_reg    <= freed_reg;
            out_bytes_reg    <= bo_reg;
            out_window_reg   <= cwnd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg  <= '0;
            busy_reg      <= '0;
            bo_reg        <= '0;
            cwnd_reg      <= sack_pkg::RESET_WINDOW;
            contig_reg    <= '0;
            recv_bits_reg <= '0;
            accepted_reg  <= 1'b0;
            assigned_reg  <= '0;
            oow_reg       <= 1'b0;
            freed_reg     <= '0;
            scan_cnt_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= release_hit;

            priority if (cmd.load)
                scan_cnt_reg <= '0;
            else if (cmd.send_next || issue)
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);

            if (cmd.load)
            begin
                accepted_reg <= 1'b0;
                assigned_reg <= '0;
                oow_reg      <= 1'b0;
                freed_reg    <= '0;
            end

            if (cmd.send_commit)
            begin
                busy_reg[idx] <= 1'b1;
                bo_reg        <= bo_add;
                assigned_reg  <= next_seq_reg;
                next_seq_reg  <= next_seq_reg + SEQ_W'(1);
                accepted_reg  <= 1'b1;
            end

            // release stage
            if (p2_valid_reg)
            begin
                busy_reg[p2_idx_reg] <= 1'b0;
                bo_reg               <= bo_sub;
                freed_reg            <= freed_reg + sack_pkg::FREED_W'(1);
            end

            priority if (cfg_write)
                cwnd_reg <= cfg_data;
            else if (p2_valid_reg)
                cwnd_reg <= cwnd_sat;

            // receive window: mark once, then slide over the filled head
            if (cmd.recv_mark)
            begin
                accepted_reg <= 1'b1;
                if (mark_sum[SEQ_W])
                begin
                    if (mark_sum[SEQ_W-1:BIX_W] != '0)
                        oow_reg <= 1'b1;
                    else
                        recv_bits_reg <= recv_bits_reg |
                            (sack_pkg::BITMAP_W'(1) << mark_sum[BIX_W-1:0]);
                end
            end
            else if (cmd.recv_run && recv_bits_reg[0])
            begin
                recv_bits_reg <= recv_bits_reg >> 1;
                contig_reg    <= contig_reg + SEQ_W'(1);
            end

            priority if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid          = out_valid_reg;
    assign rsp_accepted       = out_accepted_reg;
    assign rsp_assigned_seq   = out_assigned_reg;
    assign rsp_local_ack      = out_ack_reg;
    assign rsp_local_bitmap   = out_bitmap_reg;
    assign rsp_out_of_window  = out_oow_reg;
    assign rsp_freed_count    = out_freed_reg;
    assign rsp_inflight_bytes = out_bytes_reg;
    assign rsp_window_bytes   = out_window_reg;

endmodule

// ===== rtl/core/sack_checker.sv =====
// sack_checker: port-level checks on the selective-ack scoreboard core,
// bound to the top level. Depends on sack_pkg.
module sack_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_accepted,
    input logic [sack_pkg::SEQ_W-1:0]    rsp_assigned_seq,
    input logic [sack_pkg::SEQ_W-1:0]    rsp_local_ack,
    input logic                          rsp_out_of_window,
    input logic [sack_pkg::FREED_W-1:0]  rsp_freed_count
);

    // one request in the engine at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_local_ack) &&
                                    $stable(rsp_assigned_seq))
        else $error("stalled response changed");

    // a refused send leaves no trace in the result
    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_accepted |-> rsp_assigned_seq == '0 &&
                                       rsp_freed_count == '0 && !rsp_out_of_window)
        else $error("refused send carries results");

    a_freed_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_freed_count <= sack_pkg::FREED_W'(sack_pkg::BITMAP_W))
        else $error("freed count beyond slot count");

endmodule

bind selective_ack_scoreboard_core sack_checker u_sack_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_ch.valid),
    .req_ready         (req_ch.ready),
    .rsp_valid         (rsp_ch.valid),
    .rsp_ready         (rsp_ch.ready),
    .rsp_accepted      (rsp_ch.accepted),
    .rsp_assigned_seq  (rsp_ch.assigned_seq),
    .rsp_local_ack     (rsp_ch.local_ack),
    .rsp_out_of_window (rsp_ch.out_of_window),
    .rsp_freed_count   (rsp_ch.freed_count)
);
